// ===== rtl/sjpp_pkg.sv =====
`timescale 1ns / 1ps

package sjpp_pkg;

   localparam int PALETTE_CAPACITY = 128;
   localparam int JOINT_COUNT      = 256;

   localparam int JOINT_W         = 8;
   localparam int JOINTS_PER_VERT = 4;
   localparam int VERTS_PER_TRI   = 3;
   localparam int JOINTS_PER_TRI  = JOINTS_PER_VERT * VERTS_PER_TRI;
   localparam int VERT_W          = JOINT_W * JOINTS_PER_VERT;
   localparam int TRI_JOINTS_W    = VERT_W * VERTS_PER_TRI;

   localparam int TRI_W   = 24;
   localparam int ADDED_W = 4;
   localparam int SIZE_W  = 8;
   localparam int SLOT_W  = 7;

   localparam int COUNT_W     = $clog2(PALETTE_CAPACITY + 1);
   localparam int JIDX_W      = $clog2(JOINT_COUNT);
   localparam int FRESH_IDX_W = $clog2(JOINTS_PER_TRI);

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef struct packed {
      logic [JOINT_W-1:0] rd_joint;
      logic               wr_en;
      logic [JOINT_W-1:0] wr_joint;
      logic [SLOT_W-1:0]  wr_slot;
   } table_req_type;

   typedef struct packed {
      logic              used;
      logic [SLOT_W-1:0] slot;
   } table_rsp_type;

   typedef struct packed {
      logic               accepted;
      logic [TRI_W-1:0]   triangle_echo;
      logic [ADDED_W-1:0] joints_added;
      logic [SIZE_W-1:0]  palette_size;
      logic [SLOT_W-1:0]  local_slot;
      logic               found;
   } result_type;

endpackage

// ===== rtl/sjpp_ram.sv =====
`timescale 1ns / 1ps

module sjpp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sjpp_table.sv =====
`timescale 1ns / 1ps

module sjpp_table import sjpp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  table_req_type req,
   output table_rsp_type rsp
);

   logic [JOINT_COUNT-1:0] used_ff;
   logic [JOINT_COUNT-1:0] used_in;
   logic [JIDX_W-1:0]      rd_idx;
   logic [JIDX_W-1:0]      wr_idx;
   logic                   rd_ok;
   logic [SLOT_W-1:0]      slot_rd;

   assign rd_idx = req.rd_joint[JIDX_W-1:0];
   assign wr_idx = req.wr_joint[JIDX_W-1:0];
   assign rd_ok  = {1'b0, req.rd_joint} < (JOINT_W + 1)'(JOINT_COUNT);

   always_comb begin
      used_in = used_ff;
      if (req.wr_en) begin
         used_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   sjpp_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (JOINT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (req.wr_en),
      .wr_addr (wr_idx),
      .wr_data (req.wr_slot),
      .rd_addr (rd_idx),
      .rd_data (slot_rd)
   );

   assign rsp.used = rd_ok && used_ff[rd_idx];
   assign rsp.slot = slot_rd;

endmodule

// ===== rtl/sjpp_ctrl.sv =====
`timescale 1ns / 1ps

module sjpp_ctrl import sjpp_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    op,
   input  logic [TRI_W-1:0]        tri_idx,
   input  logic [TRI_JOINTS_W-1:0] joints,
   input  logic [JOINT_W-1:0]      query,
   input  logic                    rsp_free,
   input  table_rsp_type           tbl_rsp,
   output table_req_type           tbl_req,
   output result_type              res,
   output logic                    res_load,
   output logic                    idle
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_COMMIT,
      S_LOOKUP,
      S_LREAD,
      S_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [TRI_JOINTS_W-1:0] joints_ff, joints_in;
   logic [TRI_W-1:0]        tri_ff, tri_in;
   logic [JOINT_W-1:0]      query_ff, query_in;
   logic [FRESH_IDX_W-1:0]  scan_ff, scan_in;
   logic [ADDED_W-1:0]      nfresh_ff, nfresh_in;
   logic [FRESH_IDX_W-1:0]  commit_ff, commit_in;
   logic [JOINT_W-1:0]      fresh_ff [JOINTS_PER_TRI];
   logic [JOINT_W-1:0]      fresh_in [JOINTS_PER_TRI];
   logic                    bad_ff, bad_in;
   logic                    hit_ff, hit_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   result_type              res_ff, res_in;

   logic [JOINT_W-1:0]      cur_joint;
   logic                    cur_bad;
   logic                    cur_dup;
   logic                    cur_fresh;
   logic [COUNT_W:0]        need_sum;
   logic                    fits;

   assign cur_joint = joints_ff[JOINT_W-1:0];
   assign cur_bad   = {1'b0, cur_joint} >= (JOINT_W + 1)'(JOINT_COUNT);

   always_comb begin
      cur_dup = 1'b0;
      for (int i = 0; i < JOINTS_PER_TRI; i++) begin
         if ((ADDED_W'(i) < nfresh_ff) && (fresh_ff[i] == cur_joint)) begin
            cur_dup = 1'b1;
         end
      end
   end

   assign cur_fresh = !cur_bad && !tbl_rsp.used && !cur_dup;
   assign need_sum  = (COUNT_W + 1)'(count_ff) + (COUNT_W + 1)'(nfresh_ff);
   assign fits      = need_sum <= (COUNT_W + 1)'(PALETTE_CAPACITY);

   always_comb begin
      tbl_req.rd_joint = (state_ff == S_SCAN) ? cur_joint : query_ff;
      tbl_req.wr_en    = (state_ff == S_COMMIT);
      tbl_req.wr_joint = fresh_ff[commit_ff];
      tbl_req.wr_slot  = SLOT_W'(count_ff);
   end

   always_comb begin
      state_in  = state_ff;
      joints_in = joints_ff;
      tri_in    = tri_ff;
      query_in  = query_ff;
      scan_in   = scan_ff;
      nfresh_in = nfresh_ff;
      commit_in = commit_ff;
      fresh_in  = fresh_ff;
      bad_in    = bad_ff;
      hit_in    = hit_ff;
      count_in  = count_ff;
      res_in    = res_ff;
      res_load  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               joints_in = joints;
               tri_in    = tri_idx;
               query_in  = query;
               scan_in   = '0;
               nfresh_in = '0;
               bad_in    = 1'b0;
               state_in  = (op == OP_LOOKUP) ? S_LOOKUP : S_SCAN;
            end
         end
         S_SCAN: begin
            if (cur_fresh) begin
               fresh_in[nfresh_ff[FRESH_IDX_W-1:0]] = cur_joint;
               nfresh_in = nfresh_ff + 1'b1;
            end
            bad_in    = bad_ff || cur_bad;
            joints_in = joints_ff >> JOINT_W;
            scan_in   = scan_ff + 1'b1;
            if (scan_ff == FRESH_IDX_W'(JOINTS_PER_TRI - 1)) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            res_in.accepted      = 1'b0;
            res_in.triangle_echo = tri_ff;
            res_in.joints_added  = '0;
            res_in.palette_size  = SIZE_W'(count_ff);
            res_in.local_slot    = '0;
            res_in.found         = 1'b0;
            if (bad_ff || !fits) begin
               state_in = S_DONE;
            end else if (nfresh_ff == '0) begin
               res_in.accepted = 1'b1;
               state_in        = S_DONE;
            end else begin
               commit_in = '0;
               state_in  = S_COMMIT;
            end
         end
         S_COMMIT: begin
            count_in  = count_ff + 1'b1;
            commit_in = commit_ff + 1'b1;
            if (ADDED_W'(commit_ff) == nfresh_ff - 1'b1) begin
               res_in.accepted     = 1'b1;
               res_in.joints_added = nfresh_ff;
               res_in.palette_size = SIZE_W'(count_ff + 1'b1);
               state_in            = S_DONE;
            end
         end
         S_LOOKUP: begin
            hit_in   = tbl_rsp.used;
            state_in = S_LREAD;
         end
         S_LREAD: begin
            res_in.accepted      = 1'b0;
            res_in.triangle_echo = '0;
            res_in.joints_added  = '0;
            res_in.palette_size  = SIZE_W'(count_ff);
            res_in.local_slot    = hit_ff ? tbl_rsp.slot : '0;
            res_in.found         = hit_ff;
            state_in             = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               res_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      joints_ff <= joints_in;
      tri_ff    <= tri_in;
      query_ff  <= query_in;
      scan_ff   <= scan_in;
      nfresh_ff <= nfresh_in;
      commit_ff <= commit_in;
      fresh_ff  <= fresh_in;
      bad_ff    <= bad_in;
      hit_ff    <= hit_in;
      res_ff    <= res_in;
   end

   assign res  = res_ff;
   assign idle = (state_ff == S_IDLE);

endmodule

// ===== rtl/skin_joint_palette_partitioner_core.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// req_     in         req_valid / req_ready  operation, triangle index, 3 x 4 joints, query
// rsp_     out        rsp_valid / rsp_ready  accepted, echo, joints added, size, slot, found
//
// Add transaction, N = new joints (0..12): the scan state walks the twelve joints
// through one mask lookup and compare unit, the decide state checks range and
// capacity, then the commit state writes one slot RAM entry per appended joint.
// Lookup transaction: S_LOOKUP then S_LREAD, which takes the registered slot RAM read.
// Reset clears the joint mask and palette count at once; no clearing pass.
// A new transaction is taken while the previous result waits in the rsp_ register.
module skin_joint_palette_partitioner_core import sjpp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [TRI_W-1:0]   req_triangle_index,
   input  logic [VERT_W-1:0]  req_vertex0_joints,
   input  logic [VERT_W-1:0]  req_vertex1_joints,
   input  logic [VERT_W-1:0]  req_vertex2_joints,
   input  logic [JOINT_W-1:0] req_query_joint,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_accepted,
   output logic [TRI_W-1:0]   rsp_triangle_echo,
   output logic [ADDED_W-1:0] rsp_joints_added,
   output logic [SIZE_W-1:0]  rsp_palette_size,
   output logic [SLOT_W-1:0]  rsp_local_slot,
   output logic               rsp_found
);

   table_req_type tbl_req;
   table_rsp_type tbl_rsp;
   result_type    res;
   result_type    out_ff;
   logic          rsp_valid_ff;
   logic          rsp_free;
   logic          res_load;
   logic          idle;
   logic          start;

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign start    = req_valid && idle;

   sjpp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .op       (req_operation),
      .tri_idx  (req_triangle_index),
      .joints   ({req_vertex2_joints, req_vertex1_joints, req_vertex0_joints}),
      .query    (req_query_joint),
      .rsp_free (rsp_free),
      .tbl_rsp  (tbl_rsp),
      .tbl_req  (tbl_req),
      .res      (res),
      .res_load (res_load),
      .idle     (idle)
   );

   sjpp_table u_table (
      .clock (clock),
      .reset (reset),
      .req   (tbl_req),
      .rsp   (tbl_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_load) begin
         out_ff <= res;
      end
   end

   assign req_ready         = idle;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = out_ff.accepted;
   assign rsp_triangle_echo = out_ff.triangle_echo;
   assign rsp_joints_added  = out_ff.joints_added;
   assign rsp_palette_size  = out_ff.palette_size;
   assign rsp_local_slot    = out_ff.local_slot;
   assign rsp_found         = out_ff.found;

endmodule

// ===== rtl/sjpp_checker.sv =====
`timescale 1ns / 1ps

module sjpp_checker import sjpp_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_accepted,
   input logic [TRI_W-1:0]   rsp_triangle_echo,
   input logic [ADDED_W-1:0] rsp_joints_added,
   input logic [SIZE_W-1:0]  rsp_palette_size,
   input logic [SLOT_W-1:0]  rsp_local_slot,
   input logic               rsp_found
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accepted)
         && $stable(rsp_triangle_echo) && $stable(rsp_joints_added)
         && $stable(rsp_palette_size) && $stable(rsp_local_slot) && $stable(rsp_found))
      else $error("result changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after a transaction was taken");

   a_found_is_lookup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> !rsp_accepted && rsp_joints_added == '0
         && rsp_triangle_echo == '0)
      else $error("lookup result carries add fields");

   a_added_needs_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_joints_added != '0 |-> rsp_accepted && !rsp_found
         && rsp_local_slot == '0)
      else $error("joints added without acceptance");

endmodule

bind skin_joint_palette_partitioner_core sjpp_checker u_sjpp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_accepted      (rsp_accepted),
   .rsp_triangle_echo (rsp_triangle_echo),
   .rsp_joints_added  (rsp_joints_added),
   .rsp_palette_size  (rsp_palette_size),
   .rsp_local_slot    (rsp_local_slot),
   .rsp_found         (rsp_found)
);

// ===== tb/sv/tb_skin_joint_palette_partitioner_core.sv =====
`timescale 1ns / 1ps

module tb_skin_joint_palette_partitioner_core;
   import sjpp_pkg::*;

   localparam int CLK_HIGH_NS   = 6;
   localparam int CLK_LOW_NS    = 6;
   localparam int RESET_CYCLES  = 4;
   localparam int SETTLE_CYCLES = 60;
   localparam int PRINT_CAP     = 40;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_operation = OP_ADD;
   logic [TRI_W-1:0]   req_triangle_index = '0;
   logic [VERT_W-1:0]  req_vertex0_joints = '0;
   logic [VERT_W-1:0]  req_vertex1_joints = '0;
   logic [VERT_W-1:0]  req_vertex2_joints = '0;
   logic [JOINT_W-1:0] req_query_joint = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_accepted;
   logic [TRI_W-1:0]   rsp_triangle_echo;
   logic [ADDED_W-1:0] rsp_joints_added;
   logic [SIZE_W-1:0]  rsp_palette_size;
   logic [SLOT_W-1:0]  rsp_local_slot;
   logic               rsp_found;

   // palette state as the block should hold it
   bit                 joint_used [JOINT_COUNT];
   logic [SLOT_W-1:0]  joint_slot [JOINT_COUNT];
   int                 palette_fill = 0;
   logic [JOINT_W-1:0] palette_joints [$];
   result_type         pending_results [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   int mismatch_count = 0;
   int results_checked = 0;
   int transactions_sent = 0;
   int adds_taken = 0;
   int adds_refused = 0;
   int lookups_sent = 0;
   int lookup_hits = 0;

   skin_joint_palette_partitioner_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_triangle_index (req_triangle_index),
      .req_vertex0_joints (req_vertex0_joints),
      .req_vertex1_joints (req_vertex1_joints),
      .req_vertex2_joints (req_vertex2_joints),
      .req_query_joint    (req_query_joint),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_accepted       (rsp_accepted),
      .rsp_triangle_echo  (rsp_triangle_echo),
      .rsp_joints_added   (rsp_joints_added),
      .rsp_palette_size   (rsp_palette_size),
      .rsp_local_slot     (rsp_local_slot),
      .rsp_found          (rsp_found)
   );

   always begin
      #CLK_HIGH_NS clock = 1'b1;
      #CLK_LOW_NS  clock = 1'b0;
   end

   initial begin
      #(20_000_000);
      $display("skin_joint_palette_partitioner_core verification failed");
      $finish;
   end

   function automatic result_type partition_palette_step(
      input logic               op,
      input logic [TRI_W-1:0]   tri_idx,
      input logic [VERT_W-1:0]  v0,
      input logic [VERT_W-1:0]  v1,
      input logic [VERT_W-1:0]  v2,
      input logic [JOINT_W-1:0] query
   );
      result_type               res;
      logic [TRI_JOINTS_W-1:0]  all_joints;
      logic [JOINT_W-1:0]       fresh [$];
      bit                       taken [JOINT_COUNT];
      bit                       bad;
      int                       j;
      res = '0;
      bad = 1'b0;
      res.palette_size = SIZE_W'(palette_fill);
      if (op == OP_LOOKUP) begin
         if (int'(query) < JOINT_COUNT && joint_used[query]) begin
            res.found      = 1'b1;
            res.local_slot = joint_slot[query];
         end
         return res;
      end
      res.triangle_echo = tri_idx;
      all_joints = {v2, v1, v0};
      for (int n = 0; n < JOINTS_PER_TRI; n++) begin
         j = int'(all_joints[n*JOINT_W +: JOINT_W]);
         if (j >= JOINT_COUNT) begin
            bad = 1'b1;
         end else if (!joint_used[j] && !taken[j]) begin
            taken[j] = 1'b1;
            fresh.push_back(JOINT_W'(j));
         end
      end
      if (bad || palette_fill + fresh.size() > PALETTE_CAPACITY) begin
         return res;
      end
      foreach (fresh[k]) begin
         joint_slot[fresh[k]] = SLOT_W'(palette_fill);
         joint_used[fresh[k]] = 1'b1;
         palette_joints.push_back(fresh[k]);
         palette_fill++;
      end
      res.accepted     = 1'b1;
      res.joints_added = ADDED_W'(fresh.size());
      res.palette_size = SIZE_W'(palette_fill);
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) begin
         $display("MISMATCH at %0t ns: %s", $time, msg);
      end
   endtask

   task automatic offer_transaction(
      input logic               op,
      input logic [TRI_W-1:0]   tri_idx,
      input logic [VERT_W-1:0]  v0,
      input logic [VERT_W-1:0]  v1,
      input logic [VERT_W-1:0]  v2,
      input logic [JOINT_W-1:0] query
   );
      int         gap;
      result_type res;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_triangle_index <= tri_idx;
      req_vertex0_joints <= v0;
      req_vertex1_joints <= v1;
      req_vertex2_joints <= v2;
      req_query_joint    <= query;
      do @(posedge clock); while (!req_ready);
      res = partition_palette_step(op, tri_idx, v0, v1, v2, query);
      pending_results.push_back(res);
      transactions_sent++;
      if (op == OP_LOOKUP) begin
         lookups_sent++;
         if (res.found) lookup_hits++;
      end else if (res.accepted) begin
         adds_taken++;
      end else begin
         adds_refused++;
      end
   endtask

   task automatic check_palette_result();
      result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("result transaction with nothing pending");
         return;
      end
      want = pending_results.pop_front();
      results_checked++;
      if (rsp_accepted !== want.accepted)
         report_mismatch($sformatf("accepted got %0b want %0b", rsp_accepted, want.accepted));
      if (rsp_triangle_echo !== want.triangle_echo)
         report_mismatch($sformatf("triangle_echo got %h want %h",
                                   rsp_triangle_echo, want.triangle_echo));
      if (rsp_joints_added !== want.joints_added)
         report_mismatch($sformatf("joints_added got %0d want %0d",
                                   rsp_joints_added, want.joints_added));
      if (rsp_palette_size !== want.palette_size)
         report_mismatch($sformatf("palette_size got %0d want %0d",
                                   rsp_palette_size, want.palette_size));
      if (rsp_local_slot !== want.local_slot)
         report_mismatch($sformatf("local_slot got %0d want %0d",
                                   rsp_local_slot, want.local_slot));
      if (rsp_found !== want.found)
         report_mismatch($sformatf("found got %0b want %0b", rsp_found, want.found));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_palette_result();
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [JOINT_W-1:0] pick_joint();
      if (palette_joints.size() == 0 || $urandom_range(59) == 0) begin
         return JOINT_W'($urandom_range(255));
      end
      return palette_joints[$urandom_range(palette_joints.size() - 1)];
   endfunction

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_fresh_triangle(input int n_new);
      logic [TRI_JOINTS_W-1:0] joints;
      logic [JOINT_W-1:0]      spare [$];
      for (int j = 0; j < JOINT_COUNT; j++) begin
         if (!joint_used[j]) spare.push_back(JOINT_W'(j));
      end
      spare.shuffle();
      for (int n = 0; n < JOINTS_PER_TRI; n++) begin
         joints[n*JOINT_W +: JOINT_W] = (n < n_new) ? spare[n] : spare[0];
      end
      offer_transaction(OP_ADD, TRI_W'($urandom), joints[VERT_W-1:0],
                        joints[2*VERT_W-1:VERT_W], joints[3*VERT_W-1:2*VERT_W],
                        JOINT_W'($urandom));
   endtask

   task automatic test_directed_basics();
      offer_transaction(OP_LOOKUP, '0, '0, '0, '0, 8'h00);
      offer_transaction(OP_LOOKUP, '1, '1, '1, '1, 8'hFF);
      offer_transaction(OP_ADD, 24'h000000, 32'h00000000, 32'h00000000, 32'h00000000, 8'hFF);
      offer_transaction(OP_ADD, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'h00);
      offer_transaction(OP_ADD, 24'h123456, 32'h04030201, 32'h01020304, 32'h00FF0403, 8'h00);
      offer_transaction(OP_ADD, 24'hABCDEF, 32'h08070605, 32'h0C0B0A09, 32'h100F0E0D, 8'h00);
      offer_transaction(OP_ADD, 24'h800000, 32'hFF000102, 32'h10101010, 32'h0A0B0C0D, 8'h00);
      offer_transaction(OP_ADD, 24'h000001, 32'h11111111, 32'h11FF0011, 32'h12121211, 8'h00);
      offer_transaction(OP_LOOKUP, '0, '0, '0, '0, 8'h00);
      offer_transaction(OP_LOOKUP, '0, '0, '0, '0, 8'hFF);
      offer_transaction(OP_LOOKUP, '0, '0, '0, '0, 8'h10);
      offer_transaction(OP_LOOKUP, '0, '0, '0, '0, 8'h03);
      offer_transaction(OP_LOOKUP, '0, '0, '0, '0, 8'h12);
      offer_transaction(OP_LOOKUP, '1, '1, '1, '1, 8'h13);
      offer_transaction(OP_LOOKUP, '0, '0, '0, '0, 8'h80);
   endtask

   task automatic test_random_traffic(input int n_items);
      logic [TRI_JOINTS_W-1:0] joints;
      logic [JOINT_W-1:0]      query;
      bit                      noisy;
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(99) < 30) begin
            if (palette_joints.size() > 0 && $urandom_range(1) == 1)
               query = palette_joints[$urandom_range(palette_joints.size() - 1)];
            else
               query = JOINT_W'($urandom_range(255));
            offer_transaction(OP_LOOKUP, TRI_W'($urandom), $urandom, $urandom, $urandom, query);
         end else begin
            noisy = ($urandom_range(59) == 0);
            for (int n = 0; n < JOINTS_PER_TRI; n++) begin
               joints[n*JOINT_W +: JOINT_W] = noisy ? JOINT_W'($urandom_range(255))
                                                    : pick_joint();
            end
            offer_transaction(OP_ADD, TRI_W'($urandom), joints[VERT_W-1:0],
                              joints[2*VERT_W-1:VERT_W], joints[3*VERT_W-1:2*VERT_W],
                              JOINT_W'($urandom));
         end
      end
   endtask

   task automatic test_capacity_boundary();
      int room;
      room = PALETTE_CAPACITY - palette_fill;
      while (room > JOINTS_PER_TRI) begin
         send_fresh_triangle(JOINTS_PER_TRI);
         room = PALETTE_CAPACITY - palette_fill;
      end
      if (room > 0) begin
         if (room < JOINTS_PER_TRI) send_fresh_triangle(room + 1);
         send_fresh_triangle(room);
      end
      send_fresh_triangle(1);
   endtask

   task automatic test_lookup_sweep();
      for (int j = 0; j < JOINT_COUNT; j++) begin
         offer_transaction(OP_LOOKUP, TRI_W'($urandom), $urandom, $urandom, $urandom,
                           JOINT_W'(j));
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 37;
      recv_idle_pct = 81;
      test_directed_basics();
      test_random_traffic(150);

      send_idle_pct = 81;
      recv_idle_pct = 37;
      test_random_traffic(100);
      hold_until_drained();
      test_capacity_boundary();
      test_random_traffic(60);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(150);
      test_lookup_sweep();

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d transactions: %0d adds taken, %0d adds refused, %0d lookups (%0d hits).",
               transactions_sent, adds_taken, adds_refused, lookups_sent, lookup_hits);
      $display("Palette closed at %0d of %0d slots; %0d results checked, %0d mismatches.",
               palette_fill, PALETTE_CAPACITY, results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("skin_joint_palette_partitioner_core verification clean");
      end else begin
         $display("skin_joint_palette_partitioner_core verification failed");
      end
      $finish;
   end

endmodule

// ===== skin_joint_palette_partitioner_core.f =====
rtl/sjpp_pkg.sv
rtl/sjpp_ram.sv
rtl/sjpp_table.sv
rtl/sjpp_ctrl.sv
rtl/skin_joint_palette_partitioner_core.sv
rtl/sjpp_checker.sv
tb/sv/tb_skin_joint_palette_partitioner_core.sv
